@@ src/hmt_pkg.sv @@
// Shared constants, codes and types of the heartbeat membership table.
package hmt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_PORT = 2'd2;

  // Register reset values.
  localparam logic [7:0] TIMEOUT_RESET = 8'd5;

  // Input commands.
  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_REPORT  = 2'd0;
  localparam logic [1:0] KIND_REMOVED = 2'd1;
  localparam logic [1:0] KIND_TICK    = 2'd2;

  // One stored member.
  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] beat;
    logic [31:0] stamp;
  } entry_t;

  // The pair and heartbeat being looked up during a scan.
  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] beat;
  } key_t;

  // Outcome of evaluating one entry against the key.
  typedef struct packed {
    logic match;
    logic newer;
    logic expired;
  } eval_t;

endpackage

@@ src/heartbeat_membership_table_top.sv @@
// Top level of the heartbeat membership table: sequencer, valid bits and registers.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | start, busy            | in_cmd, in_member_id, in_member_port,
//           |                        | in_report_heartbeat
//  result   | out_strobe             | out_kind, out_entry_id, out_entry_port,
//           |                        | out_was_added, out_table_full,
//           |                        | out_own_heartbeat, out_last
//  config   | cfg_we                 | cfg_idx, cfg_wdata
//
// Every transaction scans the whole table through one memory read port, one entry
// per cycle, then passes through a drain state and a write-back state; busy stays
// high from the scan to the write-back, and a new transaction is taken only while
// busy is low. Removal results appear during the scan, one per cycle; the final
// result appears in the first cycle in which busy is low again.
// Synchronous reset empties the table through its valid bits at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
module heartbeat_membership_table_top
  import hmt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_cmd,
  input  logic [31:0]          in_member_id,
  input  logic [15:0]          in_member_port,
  input  logic [31:0]          in_report_heartbeat,
  output logic                 out_strobe,
  output logic [1:0]           out_kind,
  output logic [31:0]          out_entry_id,
  output logic [15:0]          out_entry_port,
  output logic                 out_was_added,
  output logic                 out_table_full,
  output logic [31:0]          out_own_heartbeat,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [7:0]  timeout_r;
  logic [31:0] self_id_r;
  logic [15:0] self_port_r;

  // Time and own heartbeat.
  logic [31:0] cur_time_r;
  logic [31:0] self_beat_r;

  // Transaction context.
  key_t        key_r;
  logic        is_tick_r;
  logic [IDX_W-1:0] cnt_r;

  // Evaluation stage, registered from the read address in the cycle after it is issued.
  logic             ev_vld_r;
  logic [IDX_W-1:0] ev_idx_r;

  // Scan findings.
  logic             found_r;
  logic             upd_r;
  logic [IDX_W-1:0] slot_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_slot_r;

  logic [TABLE_DEPTH-1:0] vld_r;

  // Result registers.
  logic        out_strobe_r;
  logic [1:0]  out_kind_r;
  logic [31:0] out_entry_id_r;
  logic [15:0] out_entry_port_r;
  logic        out_was_added_r;
  logic        out_table_full_r;
  logic [31:0] out_own_heartbeat_r;
  logic        out_last_r;

  logic             accept;
  logic             in_done;
  logic             ent_valid;
  logic             remove;
  logic             still_valid;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  entry_t           rd_data;
  eval_t            ev_res;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign in_done = (state_r == ST_DONE);

  // Entry storage.
  hmt_entry_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (cnt_r),
    .rd_data (rd_data)
  );

  // Shared compare unit.
  hmt_eval u_eval (
    .entry_i  (rd_data),
    .key_i    (key_r),
    .cur_time (cur_time_r),
    .timeout  (timeout_r),
    .res      (ev_res)
  );

  // Per-entry decisions; a removed entry counts as free for the lookup.
  assign ent_valid   = vld_r[ev_idx_r];
  assign remove      = ev_vld_r && is_tick_r && ent_valid && ev_res.expired;
  assign still_valid = ent_valid && !remove;

  // Write-back at the end of the scan: update a newer match or insert a new pair.
  assign wr_en   = in_done && ((found_r && upd_r) || (!found_r && free_found_r));
  assign wr_addr = found_r ? slot_r : free_slot_r;
  always_comb begin
    wr_data.id    = key_r.id;
    wr_data.port  = key_r.port;
    wr_data.beat  = key_r.beat;
    wr_data.stamp = cur_time_r;
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      ev_vld_r     <= 1'b0;
      vld_r        <= '0;
      cur_time_r   <= '0;
      self_beat_r  <= '0;
      timeout_r    <= TIMEOUT_RESET;
      self_id_r    <= '0;
      self_port_r  <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ev_vld_r <= (state_r == ST_SCAN);

      // Scan address.
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == ST_SCAN && cnt_r != LAST_IDX) begin
        cnt_r <= cnt_r + 1'b1;
      end

      // A tick advances time and the own heartbeat before its scan.
      if (accept && in_cmd == CMD_TICK) begin
        cur_time_r  <= cur_time_r + 1'b1;
        self_beat_r <= self_beat_r + 1'b1;
      end

      // Valid bits: cleared on removal, set on insert.
      if (remove) begin
        vld_r[ev_idx_r] <= 1'b0;
      end
      if (in_done && !found_r && free_found_r) begin
        vld_r[free_slot_r] <= 1'b1;
      end

      // Configuration writes.
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TIMEOUT:   timeout_r   <= cfg_wdata[7:0];
          CFG_SELF_ID:   self_id_r   <= cfg_wdata[31:0];
          CFG_SELF_PORT: self_port_r <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end

      out_strobe_r <= remove || in_done;
    end
  end

  // Transaction context and scan findings.
  always_ff @(posedge clk) begin
    ev_idx_r <= cnt_r;
    if (accept) begin
      is_tick_r    <= (in_cmd == CMD_TICK);
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      if (in_cmd == CMD_TICK) begin
        key_r.id   <= self_id_r;
        key_r.port <= self_port_r;
        key_r.beat <= self_beat_r + 1'b1;
      end else begin
        key_r.id   <= in_member_id;
        key_r.port <= in_member_port;
        key_r.beat <= in_report_heartbeat;
      end
    end else if (ev_vld_r) begin
      if (still_valid && ev_res.match && !found_r) begin
        found_r <= 1'b1;
        slot_r  <= ev_idx_r;
        upd_r   <= ev_res.newer;
      end
      if (!still_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_slot_r  <= ev_idx_r;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (remove) begin
      out_kind_r          <= KIND_REMOVED;
      out_entry_id_r      <= rd_data.id;
      out_entry_port_r    <= rd_data.port;
      out_was_added_r     <= 1'b0;
      out_table_full_r    <= 1'b0;
      out_own_heartbeat_r <= '0;
      out_last_r          <= 1'b0;
    end else if (in_done) begin
      out_kind_r          <= is_tick_r ? KIND_TICK : KIND_REPORT;
      out_entry_id_r      <= key_r.id;
      out_entry_port_r    <= key_r.port;
      out_was_added_r     <= !found_r && free_found_r;
      out_table_full_r    <= !found_r && !free_found_r;
      out_own_heartbeat_r <= is_tick_r ? self_beat_r : 32'd0;
      out_last_r          <= 1'b1;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_kind          = out_kind_r;
  assign out_entry_id      = out_entry_id_r;
  assign out_entry_port    = out_entry_port_r;
  assign out_was_added     = out_was_added_r;
  assign out_table_full    = out_table_full_r;
  assign out_own_heartbeat = out_own_heartbeat_r;
  assign out_last          = out_last_r;

  // The write-back cycle always delivers the final result next.
  a_done_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |=> out_strobe && out_last)
    else $error("final result missing after write-back");

  // A removal result is never the final one of its transaction.
  a_removal_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind == KIND_REMOVED |-> !out_last)
    else $error("removal result marked as last");

  // An accepted transaction starts its scan at the first entry.
  a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == ST_SCAN && cnt_r == '0)
    else $error("scan did not start at entry zero");

  // Removals happen only while a tick is being scanned.
  a_removal_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind == KIND_REMOVED |-> $past(is_tick_r) && busy)
    else $error("removal outside a tick scan");

endmodule

@@ src/hmt_entry_mem.sv @@
// Entry storage: one write port and one registered read port.
module hmt_entry_mem
  import hmt_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/hmt_eval.sv @@
// Shared compare unit that evaluates one entry per cycle against the key.
module hmt_eval
  import hmt_pkg::*;
(
  input  entry_t      entry_i,
  input  key_t        key_i,
  input  logic [31:0] cur_time,
  input  logic [7:0]  timeout,
  output eval_t       res
);

  logic [31:0] age;

  // Age wraps modulo 2^32 and is compared unsigned.
  assign age         = cur_time - entry_i.stamp;
  assign res.expired = age > {24'd0, timeout};
  assign res.match   = (entry_i.id == key_i.id) && (entry_i.port == key_i.port);
  assign res.newer   = key_i.beat > entry_i.beat;

endmodule
